// ----- src/isp_pkg.sv -----
// Shared constants and types of the interval split point generator.
`timescale 1ns / 1ps
`default_nettype none

package isp_pkg;

  localparam int MAX_INTERVALS = 32;

  localparam int NUM_W   = 6;
  localparam int POINT_W = 17;
  localparam int RATIO_W = 16;
  localparam int STRAT_W = 2;
  localparam int ADDR_W  = 3;
  localparam int DATA_W  = 32;

  localparam logic [POINT_W-1:0] ONE_Q16     = 17'h10000;
  localparam logic [POINT_W-1:0] ZERO_Q16    = 17'h00000;
  localparam logic [RATIO_W-1:0] RATIO_RESET = 16'h8000;

  // Cut strategies; the unused code behaves as STRAT_ALWAYS.
  localparam logic [STRAT_W-1:0] STRAT_ALWAYS = 2'd0;
  localparam logic [STRAT_W-1:0] STRAT_ODD    = 2'd1;
  localparam logic [STRAT_W-1:0] STRAT_EVEN   = 2'd2;
  localparam logic [STRAT_W-1:0] STRAT_RESET  = STRAT_ALWAYS;

  // Register selects, taken from paddr[2].
  localparam logic REG_RATIO    = 1'b0;
  localparam logic REG_STRATEGY = 1'b1;

  typedef struct packed {
    logic [RATIO_W-1:0] ratio;
    logic [STRAT_W-1:0] strategy;
  } cfg_t;

endpackage

`default_nettype wire

// ----- src/isp_core.sv -----
// Split engine: interval memories, largest-interval scan, cut and ordered readout.
`timescale 1ns / 1ps
`default_nettype none

module isp_core #(
  parameter int MaxIntervals = isp_pkg::MAX_INTERVALS
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire isp_pkg::cfg_t               cfg_i,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [isp_pkg::NUM_W-1:0]   num_points_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic [isp_pkg::POINT_W-1:0]      split_point_o,
  output logic                             last_point_o
);
  import isp_pkg::*;

  localparam int IdxW  = (MaxIntervals > 1) ? $clog2(MaxIntervals) : 1;
  localparam int CntW  = $clog2(MaxIntervals + 1);
  localparam int ProdW = 2 * POINT_W;

  typedef enum logic [10:0] {
    S_IDLE      = 11'b000_0000_0001,
    S_SCAN      = 11'b000_0000_0010,
    S_SDRAIN    = 11'b000_0000_0100,
    S_MUL       = 11'b000_0000_1000,
    S_CUT       = 11'b000_0001_0000,
    S_WR_NEW    = 11'b000_0010_0000,
    S_WR_OLD    = 11'b000_0100_0000,
    S_EMIT_RD   = 11'b000_1000_0000,
    S_EMIT_WAIT = 11'b001_0000_0000,
    S_EMIT_OUT  = 11'b010_0000_0000,
    S_LAST_OUT  = 11'b100_0000_0000
  } state_e;

  // Each entry keeps its start and a link to the entry that follows it in
  // ascending order, so the readout walks the list instead of sorting.
  typedef struct packed {
    logic [POINT_W-1:0] start;
    logic [IdxW-1:0]    nxt;
  } entry_t;

  state_e state_q, state_d;

  entry_t             entry_mem_q [MaxIntervals];
  logic [POINT_W-1:0] end_mem_q   [MaxIntervals];
  entry_t             rd_entry_q;
  logic [POINT_W-1:0] rd_end_q;

  logic               mem_we;
  logic [IdxW-1:0]    mem_waddr;
  entry_t             mem_wentry;
  logic [POINT_W-1:0] mem_wend;
  logic [IdxW-1:0]    mem_raddr;

  logic [CntW-1:0] n_q, n_d;
  logic [CntW-1:0] total_q, total_d;
  logic [CntW-1:0] emit_cnt_q, emit_cnt_d;
  logic [IdxW-1:0] scan_idx_q, scan_idx_d;
  logic [IdxW-1:0] cmp_idx_q, cmp_idx_d;
  logic            cmp_vld_q, cmp_vld_d;
  logic [IdxW-1:0] ptr_q, ptr_d;
  logic            out_valid_q, out_valid_d;

  logic [POINT_W-1:0] best_size_q, best_size_d;
  logic [IdxW-1:0]    best_idx_q, best_idx_d;
  logic [POINT_W-1:0] best_start_q, best_start_d;
  logic [POINT_W-1:0] best_end_q, best_end_d;
  logic [IdxW-1:0]    best_next_q, best_next_d;
  logic [ProdW-1:0]   prod_q, prod_d;
  logic [POINT_W-1:0] cut_q, cut_d;
  logic [POINT_W-1:0] out_point_q, out_point_d;
  logic               out_last_q, out_last_d;

  logic [NUM_W-1:0]   pm1;
  logic [NUM_W-1:0]   total_lim;
  logic [CntW-1:0]    total_calc;
  logic [POINT_W-1:0] ratio_ext;
  logic [POINT_W-1:0] ratio_inv;
  logic [POINT_W-1:0] frac;
  logic [POINT_W-1:0] cmp_size;

  // Request size: at least one interval, at most the table depth.
  always_comb begin
    pm1        = (num_points_i < NUM_W'(2)) ? NUM_W'(1) : (num_points_i - NUM_W'(1));
    total_lim  = NUM_W'(MaxIntervals);
    total_calc = CntW'((pm1 > total_lim) ? total_lim : pm1);
  end

  always_comb begin
    ratio_ext = {1'b0, cfg_i.ratio};
    ratio_inv = ONE_Q16 - ratio_ext;
    case (cfg_i.strategy)
      STRAT_ODD:  frac = n_q[0] ? ratio_ext : ratio_inv;
      STRAT_EVEN: frac = n_q[0] ? ratio_inv : ratio_ext;
      default:    frac = ratio_ext;
    endcase
  end

  // Largest-interval tracking; a strict compare keeps the lowest index on ties.
  assign cmp_size = rd_end_q - rd_entry_q.start;

  always_comb begin
    best_size_d  = best_size_q;
    best_idx_d   = best_idx_q;
    best_start_d = best_start_q;
    best_end_d   = best_end_q;
    best_next_d  = best_next_q;
    if (cmp_vld_q && ((cmp_idx_q == '0) || (cmp_size > best_size_q))) begin
      best_size_d  = cmp_size;
      best_idx_d   = cmp_idx_q;
      best_start_d = rd_entry_q.start;
      best_end_d   = rd_end_q;
      best_next_d  = rd_entry_q.nxt;
    end
  end

  always_comb begin
    state_d     = state_q;
    n_d         = n_q;
    total_d     = total_q;
    emit_cnt_d  = emit_cnt_q;
    scan_idx_d  = scan_idx_q;
    cmp_idx_d   = cmp_idx_q;
    cmp_vld_d   = 1'b0;
    ptr_d       = ptr_q;
    out_valid_d = out_valid_q;
    out_point_d = out_point_q;
    out_last_d  = out_last_q;
    prod_d      = prod_q;
    cut_d       = cut_q;
    mem_we      = 1'b0;
    mem_waddr   = '0;
    mem_wentry  = '{start: ZERO_Q16, nxt: '0};
    mem_wend    = ONE_Q16;
    mem_raddr   = ptr_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          total_d    = total_calc;
          n_d        = CntW'(1);
          scan_idx_d = '0;
          ptr_d      = '0;
          emit_cnt_d = '0;
          mem_we     = 1'b1;
          state_d    = (total_calc == CntW'(1)) ? S_EMIT_RD : S_SCAN;
        end
      end
      S_SCAN: begin
        mem_raddr  = scan_idx_q;
        cmp_vld_d  = 1'b1;
        cmp_idx_d  = scan_idx_q;
        scan_idx_d = scan_idx_q + IdxW'(1);
        if (CntW'(scan_idx_q) == (n_q - CntW'(1))) begin
          state_d = S_SDRAIN;
        end
      end
      S_SDRAIN: begin
        state_d = S_MUL;
      end
      S_MUL: begin
        prod_d  = ProdW'(frac) * ProdW'(best_size_q);
        state_d = S_CUT;
      end
      S_CUT: begin
        cut_d   = POINT_W'({1'b0, best_start_q} + prod_q[ProdW-1:16]);
        state_d = S_WR_NEW;
      end
      S_WR_NEW: begin
        // The upper part goes to the new entry and links in after the old one.
        mem_we     = 1'b1;
        mem_waddr  = n_q[IdxW-1:0];
        mem_wentry = '{start: cut_q, nxt: best_next_q};
        mem_wend   = best_end_q;
        state_d    = S_WR_OLD;
      end
      S_WR_OLD: begin
        mem_we     = 1'b1;
        mem_waddr  = best_idx_q;
        mem_wentry = '{start: best_start_q, nxt: n_q[IdxW-1:0]};
        mem_wend   = cut_q;
        n_d        = n_q + CntW'(1);
        scan_idx_d = '0;
        state_d    = ((n_q + CntW'(1)) == total_q) ? S_EMIT_RD : S_SCAN;
      end
      S_EMIT_RD: begin
        mem_raddr = ptr_q;
        state_d   = S_EMIT_WAIT;
      end
      S_EMIT_WAIT: begin
        out_point_d = rd_entry_q.start;
        out_last_d  = 1'b0;
        out_valid_d = 1'b1;
        ptr_d       = rd_entry_q.nxt;
        emit_cnt_d  = emit_cnt_q + CntW'(1);
        state_d     = S_EMIT_OUT;
      end
      S_EMIT_OUT: begin
        if (!out_stall_i) begin
          if (emit_cnt_q == total_q) begin
            out_point_d = ONE_Q16;
            out_last_d  = 1'b1;
            state_d     = S_LAST_OUT;
          end else begin
            out_valid_d = 1'b0;
            state_d     = S_EMIT_RD;
          end
        end
      end
      S_LAST_OUT: begin
        if (!out_stall_i) begin
          out_valid_d = 1'b0;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      entry_mem_q[mem_waddr] <= mem_wentry;
      end_mem_q[mem_waddr]   <= mem_wend;
    end
    rd_entry_q <= entry_mem_q[mem_raddr];
    rd_end_q   <= end_mem_q[mem_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      n_q         <= '0;
      total_q     <= '0;
      emit_cnt_q  <= '0;
      scan_idx_q  <= '0;
      cmp_idx_q   <= '0;
      cmp_vld_q   <= 1'b0;
      ptr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      n_q         <= n_d;
      total_q     <= total_d;
      emit_cnt_q  <= emit_cnt_d;
      scan_idx_q  <= scan_idx_d;
      cmp_idx_q   <= cmp_idx_d;
      cmp_vld_q   <= cmp_vld_d;
      ptr_q       <= ptr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_size_q  <= best_size_d;
    best_idx_q   <= best_idx_d;
    best_start_q <= best_start_d;
    best_end_q   <= best_end_d;
    best_next_q  <= best_next_d;
    prod_q       <= prod_d;
    cut_q        <= cut_d;
    out_point_q  <= out_point_d;
    out_last_q   <= out_last_d;
  end

  assign in_stall_o    = (state_q != S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign split_point_o = out_point_q;
  assign last_point_o  = out_last_q;

  a_out_only_in_emit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (state_q == S_EMIT_OUT || state_q == S_LAST_OUT))
    else $error("result beat outside the readout states");

  a_scan_below_total : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (n_q < total_q))
    else $error("split scan started with the table already full");

  a_cmp_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmp_vld_q |-> (CntW'(cmp_idx_q) < n_q))
    else $error("scan compared an entry beyond the live intervals");

  a_best_ordered : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MUL) |-> (best_end_q >= best_start_q))
    else $error("selected interval ends before it starts");

  a_last_after_all : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LAST_OUT) |-> (emit_cnt_q == total_q && last_point_o))
    else $error("closing beat sent before all interval starts");

endmodule

`default_nettype wire

// ----- src/interval_split_point_generator_top.sv -----
// Top level: register port for ratio and strategy, and the split engine.
//
// One request beat on num_points_i asks for P split points (P below 2 counts
// as 2, the interval count P-1 saturates at MaxIntervals). The block starts
// from [0,1), repeatedly cuts the largest interval and then returns the
// interval starts in ascending order, one result beat each, followed by a
// closing beat 65536 with last_point_o set. Values are Q1.16.
// The request stall stays high from acceptance until the closing beat has
// been taken, so one request is in flight at a time.
// For T intervals the engine accepts the request, then for each cut at
// count n runs a scan of n memory reads followed by drain, multiply, add
// and two write-backs, then reads out each interval start in turn and sends
// the closing beat. The scan over the single read port of the interval
// memories takes the bulk of the run time.
// While the receiver stalls, the pending result beat holds and the read
// pointer does not advance. Reset returns the engine to idle, ratio to 0.5
// and strategy to 0; the interval memories need no clearing, since each
// request writes every entry before reading it.
`timescale 1ns / 1ps
`default_nettype none

module interval_split_point_generator_top #(
  parameter int MaxIntervals = isp_pkg::MAX_INTERVALS
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [isp_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [isp_pkg::DATA_W-1:0]   pwdata,
  output logic      [isp_pkg::DATA_W-1:0]   prdata,
  output logic                              pready,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic [isp_pkg::NUM_W-1:0]    num_points_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic      [isp_pkg::POINT_W-1:0]  split_point_o,
  output logic                              last_point_o
);
  import isp_pkg::*;

  cfg_t cfg_q, cfg_d;
  logic cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_wr) begin
      unique case (paddr[2])
        REG_RATIO:    cfg_d.ratio    = pwdata[RATIO_W-1:0];
        REG_STRATEGY: cfg_d.strategy = pwdata[STRAT_W-1:0];
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_RATIO:    prdata = DATA_W'(cfg_q.ratio);
      REG_STRATEGY: prdata = DATA_W'(cfg_q.strategy);
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{ratio: RATIO_RESET, strategy: STRAT_RESET};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  isp_core #(
    .MaxIntervals (MaxIntervals)
  ) u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .num_points_i  (num_points_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .split_point_o (split_point_o),
    .last_point_o  (last_point_o)
  );

endmodule

`default_nettype wire
